// ===== rtl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned RowW   = 128;
  localparam int unsigned Rows   = 15;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_0 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_1 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_2 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD_3 = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r=8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [WordW-1:0] subw(input logic [WordW-1:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte b sits at bits 127-8b; byte index is 4*column + row
  function automatic logic [RowW-1:0] round_fn(input logic [RowW-1:0] s,
                                               input logic last);
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] all;
    logic [RowW-1:0] r;
    for (int b = 0; b < 16; b++) begin
      t[b] = sbox(s[127 - 8*(4*(((b >> 2) + (b & 3)) & 3) + (b & 3)) -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      o[4*c]   = t[4*c]   ^ all ^ xt(t[4*c]   ^ t[4*c+1]);
      o[4*c+1] = t[4*c+1] ^ all ^ xt(t[4*c+1] ^ t[4*c+2]);
      o[4*c+2] = t[4*c+2] ^ all ^ xt(t[4*c+2] ^ t[4*c+3]);
      o[4*c+3] = t[4*c+3] ^ all ^ xt(t[4*c+3] ^ t[4*c]);
    end
    for (int b = 0; b < 16; b++) begin
      r[127 - 8*b -: 8] = last ? t[b] : o[b];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_if.sv =====
`default_nettype none
interface aes_in_if import aes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BlockW-1:0] plain_high;
  logic [BlockW-1:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface aes_out_if import aes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BlockW-1:0] cipher_high;
  logic [BlockW-1:0] cipher_low;
  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

interface aes_cfg_if import aes_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [BlockW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/aes_block_encrypt.sv =====
// AES block encryptor, 128/192/256-bit keys.
// Channels: plain (sink) takes one 128-bit plaintext word, cipher (source)
// gives one ciphertext word per plaintext, in order; cfg (sink, always ready)
// writes key_length (index 0) and key_word_0..3 (indexes 1..4); other indexes
// are dropped. Write cfg only while the block is idle.
// After reset or any write to indexes 0..4 the round keys are expanded into
// a 15-row round key RAM, one key word per cycle unless a key write restarts
// it: 44, 52 or 60 words for 128, 192 or 256-bit keys. plain.ready stays low
// until the expansion is done. A block is then loaded on accept, gets the
// initial key addition in ST_ADD0 and one ST_ROUND step per round, each round
// reading its key row from the RAM in the cycle before; a new block is taken
// only once the last round has gone to the output register.
// The result sits in an output register, so a new block can be accepted while
// it waits; if the receiver stalls, the next block holds in its last round.
// Reset clears the key registers to zero, drops keys_ready and empties the
// output register; expansion then starts on its own.
`default_nettype none
module aes_block_encrypt import aes_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  aes_cfg_if.sink  cfg,
  aes_in_if.sink   plain,
  aes_out_if.source cipher
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ADD0, ST_ROUND} state_t;

  state_t            st;
  logic [1:0]        key_length;
  logic [BlockW-1:0] key_word [4];
  logic              keys_ready;
  logic [WordW-1:0]  win [8];
  logic [5:0]        widx;
  logic [2:0]        jdx;
  logic [7:0]        rc;
  logic [3:0]        rnd;
  logic [RowW-1:0]   s;
  logic [RowW-1:0]   mem [Rows];
  logic [RowW-1:0]   rdata;
  logic              cipher_valid;
  logic [BlockW-1:0] cipher_high, cipher_low;

  logic [3:0]        nk, nr, rd_addr;
  logic [5:0]        total;
  logic [BlockW-1:0] kw;
  logic [WordW-1:0]  wnk, tw, word_next;
  logic              cfg_wr, in_acc, last_rnd, can_out;

  assign cfg.ready   = 1'b1;
  assign cfg_wr      = cfg.valid;
  assign plain.ready = (st == ST_IDLE) && keys_ready;
  assign in_acc      = plain.valid && plain.ready;
  assign cipher.valid       = cipher_valid;
  assign cipher.cipher_high = cipher_high;
  assign cipher.cipher_low  = cipher_low;

  assign nk       = (key_length == 2'd0) ? 4'd4 : (key_length == 2'd1) ? 4'd6 : 4'd8;
  assign nr       = nk + 4'd6;
  assign total    = {nr, 2'b00} + 6'd3;
  assign last_rnd = (rnd == nr);
  assign can_out  = !cipher_valid || cipher.ready;
  assign rd_addr  = (st == ST_IDLE) ? 4'd0 :
                    ((st == ST_ROUND) && last_rnd) ? rnd : rnd + 4'd1;

  always_comb begin
    kw  = key_word[widx[2:1]];
    wnk = (nk == 4'd4) ? win[3] : (nk == 4'd6) ? win[5] : win[7];
    tw  = win[0];
    if (jdx == 3'd0) begin
      tw = subw({win[0][23:0], win[0][31:24]}) ^ {rc, 24'h0};
    end else if ((nk == 4'd8) && (jdx == 3'd4)) begin
      tw = subw(win[0]);
    end
    if (widx < {2'b00, nk}) begin
      word_next = widx[0] ? kw[31:0] : kw[63:32];
    end else begin
      word_next = wnk ^ tw;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (st == ST_EXPAND && widx[1:0] == 2'd3) begin
      mem[widx[5:2]] <= {win[2], win[1], win[0], word_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      key_length   <= 2'd0;
      for (int k = 0; k < 4; k++) key_word[k] <= '0;
      keys_ready   <= 1'b0;
      cipher_valid <= 1'b0;
    end else begin
      if (cipher_valid && cipher.ready && !(st == ST_ROUND && last_rnd)) begin
        cipher_valid <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg.index)
          REG_KEY_LENGTH: key_length  <= cfg.data[1:0];
          REG_KEY_WORD_0: key_word[0] <= cfg.data;
          REG_KEY_WORD_1: key_word[1] <= cfg.data;
          REG_KEY_WORD_2: key_word[2] <= cfg.data;
          REG_KEY_WORD_3: key_word[3] <= cfg.data;
          default: ;
        endcase
        if (cfg.index <= REG_KEY_WORD_3) begin
          keys_ready <= 1'b0;
          if (st == ST_EXPAND) st <= ST_IDLE;
        end
      end
      unique case (st)
        ST_IDLE: begin
          if (in_acc) begin
            s   <= {plain.plain_high, plain.plain_low};
            rnd <= 4'd0;
            st  <= ST_ADD0;
          end else if (!keys_ready && !cfg_wr) begin
            widx <= '0;
            jdx  <= '0;
            rc   <= RCON_FIRST;
            st   <= ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          win[0] <= word_next;
          for (int k = 1; k < 8; k++) win[k] <= win[k-1];
          widx <= widx + 6'd1;
          if (widx >= {2'b00, nk}) begin
            jdx <= (jdx == nk[2:0] - 3'd1) ? 3'd0 : jdx + 3'd1;
            if (jdx == 3'd0) rc <= xt(rc);
          end
          if (widx == total && !(cfg_wr && cfg.index <= REG_KEY_WORD_3)) begin
            keys_ready <= 1'b1;
            st         <= ST_IDLE;
          end
        end
        ST_ADD0: begin
          s   <= s ^ rdata;
          rnd <= rnd + 4'd1;
          st  <= ST_ROUND;
        end
        ST_ROUND: begin
          if (!last_rnd) begin
            s   <= round_fn(s, 1'b0) ^ rdata;
            rnd <= rnd + 4'd1;
          end else if (can_out) begin
            {cipher_high, cipher_low} <= round_fn(s, 1'b1) ^ rdata;
            cipher_valid <= 1'b1;
            st           <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_keyed: assert property (@(posedge clk) disable iff (rst)
    plain.valid && plain.ready |-> keys_ready)
    else $error("block accepted without expanded keys");
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && (cfg.index <= REG_KEY_WORD_3) |=> !keys_ready)
    else $error("key write did not drop keys_ready");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cipher_valid && !cipher.ready && st == ST_ROUND && last_rnd |=> st == ST_ROUND)
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_ifs.sv =====
`timescale 1ns / 100ps
`default_nettype none
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import aes_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  aes_cfg_if cfg ();
  aes_in_if  plain ();
  aes_out_if cipher ();

  aes_block_encrypt dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .plain(plain.sink), .cipher(cipher.source)
  );

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic [1:0]  key_len_q;
  logic [63:0] key_q [4];
  logic [31:0] sched [60];
  block_t      cipher_fifo [$];
  int          mismatches = 0;
  int          hold_cycles = 0;
  int          gap_max = 3;

  function automatic logic [7:0] gmul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] r;
    inv = 8'h00;
    if (a != 8'h00) begin
      for (int k = 1; k < 256; k++) begin
        p = a;
        q = k[7:0];
        r = 8'h00;
        for (int j = 0; j < 8; j++) begin
          if (q[0]) r ^= p;
          p = gmul2(p);
          q = q >> 1;
        end
        if (r == 8'h01) inv = k[7:0];
      end
    end
    r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    return r;
  endfunction

  logic [7:0] sb [256];
  initial for (int i = 0; i < 256; i++) sb[i] = sub_byte(i[7:0]);

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
  endfunction

  function automatic int key_nk();
    return (key_len_q == 2'd0) ? 4 : (key_len_q == 2'd1) ? 6 : 8;
  endfunction

  task automatic expand_schedule();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    nk = key_nk();
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul2(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endtask

  function automatic block_t encrypt_block(input block_t pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] all;
    int nr;
    block_t o;
    nr = key_nk() + 6;
    for (int b = 0; b < 8; b++) begin
      s[b] = pt.hi[63 - 8*b -: 8];
      s[b+8] = pt.lo[63 - 8*b -: 8];
    end
    for (int r = 0; r <= nr; r++) begin
      if (r > 0) begin
        for (int b = 0; b < 16; b++)
          t[b] = sb[s[4 * (((b >> 2) + (b & 3)) & 3) + (b & 3)]];
        for (int c = 0; c < 4; c++) begin
          all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          for (int j = 0; j < 4; j++)
            s[4*c+j] = (r == nr) ? t[4*c+j]
                     : t[4*c+j] ^ all ^ gmul2(t[4*c+j] ^ t[4*c+((j+1)&3)]);
        end
      end
      for (int b = 0; b < 16; b++)
        s[b] ^= sched[4*r + (b >> 2)][31 - 8*(b & 3) -: 8];
    end
    for (int b = 0; b < 8; b++) begin
      o.hi[63 - 8*b -: 8] = s[b];
      o.lo[63 - 8*b -: 8] = s[b+8];
    end
    return o;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_KEY_LENGTH) key_len_q = val[1:0];
    else if (idx <= REG_KEY_WORD_3) key_q[idx - 1] = val;
    if (idx <= REG_KEY_WORD_3) expand_schedule();
    @(posedge clk);
  endtask

  task automatic drain();
    while (cipher_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] len, input logic [63:0] k0, k1, k2, k3);
    drain();
    write_reg(REG_KEY_LENGTH, {62'h0, len});
    write_reg(REG_KEY_WORD_0, k0);
    write_reg(REG_KEY_WORD_1, k1);
    write_reg(REG_KEY_WORD_2, k2);
    write_reg(REG_KEY_WORD_3, k3);
  endtask

  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo);
    block_t pt;
    pt.hi = hi;
    pt.lo = lo;
    plain.valid      <= 1'b1;
    plain.plain_high <= hi;
    plain.plain_low  <= lo;
    @(posedge clk);
    while (!plain.ready) @(posedge clk);
    cipher_fifo.push_back(encrypt_block(pt));
    if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
      plain.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
  endtask

  task automatic idle_sender();
    plain.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    block_t exp_w;
    if (!rst && cipher.valid && cipher.ready) begin
      if (cipher_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h %h", cipher.cipher_high,
                                       cipher.cipher_low);
      end else begin
        exp_w = cipher_fifo.pop_front();
        if (cipher.cipher_high !== exp_w.hi || cipher.cipher_low !== exp_w.lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h got %h %h", exp_w.hi, exp_w.lo,
                     cipher.cipher_high, cipher.cipher_low);
        end
      end
    end
  end

  int stall_phase = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      cipher.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 23;
      cipher.ready <= (stall_phase < 12) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  task automatic test_known_vectors();
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_word(64'h0, 64'h0);
    send_word('1, '1);
    idle_sender();
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_word('1, 64'h0);
    idle_sender();
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_word(64'h0, '1);
    idle_sender();
  endtask

  task automatic test_corner_keys();
    load_key(2'd3, '1, '1, '1, '1);
    send_word(64'h0, 64'h0);
    send_word('1, '1);
    idle_sender();
    load_key(2'd0, 64'h0, 64'h0, '1, '1);
    send_word(64'h8000000000000001, 64'h0000000180000000);
    idle_sender();
    drain();
    write_reg(3'd5, rand64());
    write_reg(3'd7, rand64());
    send_word(rand64(), rand64());
    idle_sender();
    drain();
    write_reg(REG_KEY_WORD_1, rand64());
    send_word(rand64(), rand64());
    idle_sender();
  endtask

  task automatic test_random_blocks();
    for (int ph = 0; ph < 16; ph++) begin
      load_key($urandom_range(0, 3), rand64(), rand64(), rand64(), rand64());
      gap_max = (ph % 4 == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < 100; i++) begin
        if (ph == 5 && i == 10) hold_cycles <= 400;
        send_word(rand64(), rand64());
      end
      idle_sender();
    end
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    plain.valid = 1'b0;
    plain.plain_high = '0;
    plain.plain_low = '0;
    cipher.ready = 1'b0;
    key_len_q = 2'd0;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    expand_schedule();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_vectors();
    test_corner_keys();
    test_random_blocks();
    drain();
    if (mismatches == 0 && cipher_fifo.size() == 0) begin
      $display("aes_block_encrypt regression: pass");
    end else begin
      $display("aes_block_encrypt regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("aes_block_encrypt regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
